// ----- hw/rtl/h264fs_pkg.sv -----
// Package for the H.264 Annex B frame splitter.
// Holds scanner codes, NAL type constants, state and result types, saturating helpers.
// No dependencies; every other file of the block but h264fs_if imports it.
package h264fs_pkg;

    typedef enum logic [2:0] {
        SCAN_NONE  = 3'd0,
        SCAN_Z1    = 3'd1,
        SCAN_Z2    = 3'd2,
        SCAN_Z3    = 3'd3,
        SCAN_NAL   = 3'd4,
        SCAN_SLICE = 3'd5
    } t_scan;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_FIRST = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    localparam logic [4:0] NAL_SLICE     = 5'd1;
    localparam logic [4:0] NAL_SLICE_IDR = 5'd5;
    localparam logic [4:0] NAL_SEI       = 5'd6;
    localparam logic [4:0] NAL_SPS       = 5'd7;
    localparam logic [4:0] NAL_PPS       = 5'd8;
    localparam logic [7:0] BYTE_ZERO     = 8'h00;
    localparam logic [7:0] BYTE_ONE      = 8'h01;

    typedef struct packed {
        t_scan      scan;
        logic [1:0] header_count;
        logic [1:0] slice_count;
        logic       have_start;
        logic       seeking_end;
        logic       last_was_slice;
        logic [2:0] bytes_since_code;
    } t_state;

    typedef struct packed {
        t_kind      boundary_kind;
        logic [2:0] back_offset;
        logic       ended_on_header;
    } t_result;

    localparam t_state STATE_RESET = '{
        scan: SCAN_NONE, header_count: 2'd0, slice_count: 2'd0, have_start: 1'b0,
        seeking_end: 1'b0, last_was_slice: 1'b0, bytes_since_code: 3'd0
    };

    function automatic logic [1:0] sat_inc2(input logic [1:0] v);
        return (v == 2'd3) ? 2'd3 : v + 2'd1;
    endfunction

    function automatic logic [2:0] sat_inc3(input logic [2:0] v);
        return (v == 3'd7) ? 3'd7 : v + 3'd1;
    endfunction

endpackage

// ----- hw/rtl/h264fs_if.sv -----
// Handshake channels of the H.264 Annex B frame splitter: byte in, boundary out, config.
// No dependencies.
interface h264fs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

interface h264fs_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] boundary_kind;
    logic [2:0] back_offset;
    logic       ended_on_header;
    modport source (output valid, output boundary_kind, output back_offset,
                    output ended_on_header, input ready);
    modport sink   (input valid, input boundary_kind, input back_offset,
                    input ended_on_header, output ready);
endinterface

interface h264fs_cfg_if;
    logic valid;
    logic ready;
    logic header_only_mode;
    modport source (output valid, output header_only_mode, input ready);
    modport sink   (input valid, input header_only_mode, output ready);
endinterface

// ----- hw/rtl/h264fs_step.sv -----
// Combinational per-byte update: start code scan, NAL classification, frame boundary rules.
// Depends on h264fs_pkg.
module h264fs_step (
    input  h264fs_pkg::t_state  i_state,
    input  logic [7:0]          i_byte,
    input  logic                i_header_only_mode,
    output h264fs_pkg::t_state  o_state,
    output h264fs_pkg::t_result o_result
);
    import h264fs_pkg::*;

    t_state     s;
    t_kind      kind;
    logic [2:0] off;
    logic       eoh;
    logic       frame_end;
    logic [4:0] nal_type;

    assign nal_type = i_byte[4:0];

    always_comb begin
        s         = i_state;
        kind      = KIND_NONE;
        off       = 3'd0;
        eoh       = 1'b0;
        frame_end = 1'b0;

        // distance back to the code's first zero; extra zeros move that zero forward
        if (i_state.scan == SCAN_NONE && i_byte == BYTE_ZERO) begin
            s.bytes_since_code = 3'd0;
        end else if (!(i_state.scan == SCAN_Z3 && i_byte == BYTE_ZERO)) begin
            s.bytes_since_code = sat_inc3(i_state.bytes_since_code);
        end

        unique case (i_state.scan)
            SCAN_Z1: begin
                s.scan = (i_byte == BYTE_ZERO) ? SCAN_Z2 : SCAN_NONE;
            end
            SCAN_Z2: begin
                if (i_byte == BYTE_ONE)       s.scan = SCAN_NAL;
                else if (i_byte == BYTE_ZERO) s.scan = SCAN_Z3;
                else                          s.scan = SCAN_NONE;
            end
            SCAN_Z3: begin
                if (i_byte == BYTE_ONE)       s.scan = SCAN_NAL;
                else if (i_byte != BYTE_ZERO) s.scan = SCAN_NONE;
            end
            SCAN_NAL: begin
                if (nal_type == NAL_SLICE || nal_type == NAL_SLICE_IDR) begin
                    s.scan = SCAN_SLICE;
                end else begin
                    s.scan = SCAN_NONE;
                    if (nal_type == NAL_SEI || nal_type == NAL_SPS || nal_type == NAL_PPS) begin
                        s.last_was_slice = 1'b0;
                        s.header_count   = sat_inc2(i_state.header_count);
                    end
                end
            end
            SCAN_SLICE: begin
                // top bit marks the first macroblock of a picture
                if (i_byte[7]) begin
                    s.slice_count    = sat_inc2(i_state.slice_count);
                    s.last_was_slice = 1'b1;
                end
                s.scan = SCAN_NONE;
            end
            default: begin
                s.scan = (i_byte == BYTE_ZERO) ? SCAN_Z1 : SCAN_NONE;
            end
        endcase

        if (i_header_only_mode && s.header_count != 2'd0 && s.slice_count == 2'd1) begin
            frame_end = 1'b1;
        end else begin
            if (!s.have_start && s.header_count == 2'd1 && s.slice_count == 2'd0) begin
                s.have_start = 1'b1;
                kind         = KIND_FIRST;
            end
            if (!s.have_start && s.header_count == 2'd0 && s.slice_count == 2'd1) begin
                s.have_start   = 1'b1;
                s.seeking_end  = 1'b1;
                s.header_count = 2'd0;
                s.slice_count  = 2'd0;
                kind           = KIND_FIRST;
            end
            if (!s.seeking_end && s.header_count != 2'd0 && s.slice_count == 2'd1) begin
                s.seeking_end  = 1'b1;
                s.header_count = 2'd0;
                s.slice_count  = 2'd0;
            end
            if (s.seeking_end && (s.header_count != 2'd0 || s.slice_count != 2'd0)) begin
                frame_end = 1'b1;
            end
        end

        if (kind == KIND_FIRST) begin
            off = s.bytes_since_code;
        end

        // frame end: the next unit starts at this same code
        if (frame_end) begin
            kind          = KIND_END;
            off           = s.bytes_since_code;
            eoh           = !s.last_was_slice;
            s.have_start  = 1'b1;
            s.slice_count = 2'd0;
            if (s.last_was_slice) begin
                s.seeking_end  = 1'b1;
                s.header_count = 2'd0;
            end else begin
                s.seeking_end  = 1'b0;
                s.header_count = 2'd1;
            end
        end
    end

    assign o_state                  = s;
    assign o_result.boundary_kind   = kind;
    assign o_result.back_offset     = off;
    assign o_result.ended_on_header = eoh;

endmodule

// ----- hw/rtl/h264_frame_splitter.sv -----
// Top level of the H.264 Annex B frame splitter: input register, state, result register.
// Depends on h264fs_pkg, h264fs_if and h264fs_step.
//
//   channel  | dir | payload                                          | accepted when
//   i_in     | in  | stream_byte[7:0]                                 | valid & ready
//   o_out    | out | boundary_kind[1:0], back_offset[2:0], ended_on_header | valid & ready
//   i_cfg    | in  | header_only_mode                                 | valid & ready
//
// One byte per clock unless o_out stalls; a byte goes via the input and result registers.
// The rate is set by the combinational scan state update in h264fs_step, fed from the input register.
// Reset (i_rst_n low, synchronous) clears the scan state, counts, flags and the mode bit.
// A stalled output holds its result; the input register then takes a byte only while it is empty.
// The config channel is always ready.
module h264_frame_splitter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    h264fs_in_if.sink           i_in,
    h264fs_out_if.source        o_out,
    h264fs_cfg_if.sink          i_cfg
);
    import h264fs_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_out_valid;
    t_result    r_result;
    t_state     r_state;
    logic       r_header_only_mode;
    t_state     n_state;
    t_result    n_result;
    logic       advance;

    assign advance    = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    h264fs_step u_step (
        .i_state            (r_state),
        .i_byte             (r_byte),
        .i_header_only_mode (r_header_only_mode),
        .o_state            (n_state),
        .o_result           (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid         <= 1'b0;
            r_out_valid        <= 1'b0;
            r_state            <= STATE_RESET;
            r_header_only_mode <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_header_only_mode <= i_cfg.header_only_mode;
            end
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
                // commit state only when the item moves into the result register
                if (r_in_valid) begin
                    r_state <= n_state;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.stream_byte;
        end
        if (advance && r_in_valid) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.boundary_kind   = r_result.boundary_kind;
    assign o_out.back_offset     = r_result.back_offset;
    assign o_out.ended_on_header = r_result.ended_on_header;

    a_kind_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.boundary_kind == KIND_NONE ||
                         o_out.boundary_kind == KIND_FIRST ||
                         o_out.boundary_kind == KIND_END))
        else $error("boundary kind out of range");

    a_no_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.boundary_kind == KIND_NONE) |->
            (o_out.back_offset == 3'd0 && !o_out.ended_on_header))
        else $error("offset or header flag set without a boundary");

    a_header_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ended_on_header) |-> o_out.boundary_kind == KIND_END)
        else $error("header flag outside a frame end");

    a_first_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.have_start |=> r_state.have_start)
        else $error("start flag dropped after being set");

endmodule

// ----- dv/h264_frame_splitter_checker.sv -----
// Checker for the H.264 Annex B frame splitter: watches the byte, config and result channels.
// Predicts one boundary result per accepted byte and compares results in order.
// Depends on h264fs_pkg and h264fs_if.
`timescale 1ns / 100ps

module h264_frame_splitter_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    h264fs_in_if  i_in,
    h264fs_out_if i_out,
    h264fs_cfg_if i_cfg,
    output int    o_fail_count,
    output int    o_pending
);
    import h264fs_pkg::*;

    t_result    pending_boundaries[$];
    t_result    want;
    int         fail_count;

    // shadow copy of the splitter's mode and scan state
    logic       mode;
    t_scan      scan;
    logic [1:0] hdr_cnt;
    logic [1:0] slc_cnt;
    logic       have_start;
    logic       seeking;
    logic       last_slice;
    logic [2:0] back_cnt;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        fail_count++;
    endtask

    // Advance the scanner by one byte and return the boundary it reports.
    function automatic t_result scan_byte(input logic [7:0] b);
        t_result    r;
        t_scan      st;
        logic [4:0] nal;
        logic       frame_end;
        r.boundary_kind   = KIND_NONE;
        r.back_offset     = 3'd0;
        r.ended_on_header = 1'b0;
        frame_end = 1'b0;
        st = scan;

        if (st == SCAN_NONE && b == BYTE_ZERO) begin
            back_cnt = 3'd0;
        end else if (!(st == SCAN_Z3 && b == BYTE_ZERO) && back_cnt != 3'd7) begin
            back_cnt = back_cnt + 3'd1;
        end

        case (st)
            SCAN_Z1: st = (b == BYTE_ZERO) ? SCAN_Z2 : SCAN_NONE;
            SCAN_Z2: begin
                if (b == BYTE_ONE) st = SCAN_NAL;
                else if (b == BYTE_ZERO) st = SCAN_Z3;
                else st = SCAN_NONE;
            end
            SCAN_Z3: begin
                if (b == BYTE_ONE) st = SCAN_NAL;
                else if (b != BYTE_ZERO) st = SCAN_NONE;
            end
            SCAN_NAL: begin
                nal = b[4:0];
                st = SCAN_NONE;
                if (nal == NAL_SLICE || nal == NAL_SLICE_IDR) begin
                    st = SCAN_SLICE;
                end else if (nal == NAL_SEI || nal == NAL_SPS || nal == NAL_PPS) begin
                    last_slice = 1'b0;
                    if (hdr_cnt != 2'd3) hdr_cnt = hdr_cnt + 2'd1;
                end
            end
            SCAN_SLICE: begin
                // count the slice only on the first macroblock of a picture
                if (b[7]) begin
                    if (slc_cnt != 2'd3) slc_cnt = slc_cnt + 2'd1;
                    last_slice = 1'b1;
                end
                st = SCAN_NONE;
            end
            default: st = (b == BYTE_ZERO) ? SCAN_Z1 : SCAN_NONE;
        endcase

        if (mode && hdr_cnt != 2'd0 && slc_cnt == 2'd1) begin
            frame_end = 1'b1;
        end else begin
            if (!have_start && hdr_cnt == 2'd1 && slc_cnt == 2'd0) begin
                have_start = 1'b1;
                r.boundary_kind = KIND_FIRST;
            end
            if (!have_start && hdr_cnt == 2'd0 && slc_cnt == 2'd1) begin
                have_start = 1'b1;
                seeking = 1'b1;
                hdr_cnt = 2'd0;
                slc_cnt = 2'd0;
                r.boundary_kind = KIND_FIRST;
            end
            if (!seeking && hdr_cnt != 2'd0 && slc_cnt == 2'd1) begin
                seeking = 1'b1;
                hdr_cnt = 2'd0;
                slc_cnt = 2'd0;
            end
            if (seeking && (hdr_cnt != 2'd0 || slc_cnt != 2'd0)) frame_end = 1'b1;
        end

        if (r.boundary_kind == KIND_FIRST) r.back_offset = back_cnt;

        // the next frame opens at the same start code; restart the counts for it now
        if (frame_end) begin
            r.boundary_kind   = KIND_END;
            r.back_offset     = back_cnt;
            r.ended_on_header = !last_slice;
            have_start = 1'b1;
            slc_cnt = 2'd0;
            if (last_slice) begin
                seeking = 1'b1;
                hdr_cnt = 2'd0;
            end else begin
                seeking = 1'b0;
                hdr_cnt = 2'd1;
            end
        end

        scan = st;
        return r;
    endfunction

    initial begin
        fail_count = 0;
        o_fail_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode       = 1'b0;
            scan       = SCAN_NONE;
            hdr_cnt    = 2'd0;
            slc_cnt    = 2'd0;
            have_start = 1'b0;
            seeking    = 1'b0;
            last_slice = 1'b0;
            back_cnt   = 3'd0;
            pending_boundaries.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (pending_boundaries.size() == 0) begin
                    report_mismatch("result with no byte outstanding");
                end else begin
                    want = pending_boundaries.pop_front();
                    if (i_out.boundary_kind !== want.boundary_kind)
                        report_mismatch($sformatf("boundary_kind got %0d want %0d",
                                                  i_out.boundary_kind, want.boundary_kind));
                    if (i_out.back_offset !== want.back_offset)
                        report_mismatch($sformatf("back_offset got %0d want %0d",
                                                  i_out.back_offset, want.back_offset));
                    if (i_out.ended_on_header !== want.ended_on_header)
                        report_mismatch($sformatf("ended_on_header got %0d want %0d",
                                                  i_out.ended_on_header,
                                                  want.ended_on_header));
                end
            end
            if (i_cfg.valid && i_cfg.ready) mode = i_cfg.header_only_mode;
            if (i_in.valid && i_in.ready) pending_boundaries.push_back(scan_byte(i_in.stream_byte));
        end
        o_pending    <= pending_boundaries.size();
        o_fail_count <= fail_count;
    end

endmodule

// ----- dv/h264_frame_splitter_tb.sv -----
// Testbench top for the H.264 Annex B frame splitter: clock, reset, byte and result traffic.
// Drives directed and random Annex B streams; the checker predicts and compares.
// Depends on h264fs_pkg, h264fs_if, h264_frame_splitter and h264_frame_splitter_checker.
`timescale 1ns / 100ps

module h264_frame_splitter_tb;
    import h264fs_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   bytes_sent;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   hold_seq;
    int   hold_seen;
    int   target;

    h264fs_in_if  in_ch();
    h264fs_out_if out_ch();
    h264fs_cfg_if cfg_ch();

    h264_frame_splitter u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    h264_frame_splitter_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        int hold_left;
        hold_left = 0;
        hold_seen = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                hold_left = 400;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.stream_byte <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_code(input int zeros);
        repeat (zeros) send_byte(BYTE_ZERO);
        send_byte(BYTE_ONE);
    endtask

    // Drain the splitter, then write the mode register.
    task automatic write_mode(input logic m);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.header_only_mode <= m;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // One NAL unit: start code, header byte, payload.
    task automatic send_unit();
        int         pick;
        int         len;
        logic [4:0] nal;
        logic       first_mb;
        pick = $urandom_range(99);
        if (pick < 10) nal = NAL_SPS;
        else if (pick < 20) nal = NAL_PPS;
        else if (pick < 30) nal = NAL_SEI;
        else if (pick < 55) nal = NAL_SLICE;
        else if (pick < 80) nal = NAL_SLICE_IDR;
        else nal = 5'($urandom_range(31));
        send_code($urandom_range(2, 5));
        send_byte({3'($urandom_range(7)), nal});
        if (nal == NAL_SLICE || nal == NAL_SLICE_IDR) begin
            first_mb = ($urandom_range(99) < 80);
            send_byte({first_mb, 7'($urandom_range(127))});
        end
        len = $urandom_range(0, 4);
        repeat (len) send_byte(8'($urandom_range(1, 255)));
    endtask

    // Zero-heavy noise and broken start codes.
    task automatic send_noise();
        int len;
        if ($urandom_range(1) == 0) begin
            send_byte(BYTE_ZERO);
            send_byte(BYTE_ZERO);
            send_byte(8'($urandom_range(2, 255)));
        end else begin
            len = $urandom_range(1, 6);
            repeat (len) send_byte(($urandom_range(1) == 0) ? BYTE_ZERO
                                                            : 8'($urandom_range(255)));
        end
    endtask

    task automatic run_random(input int count);
        target = bytes_sent + count;
        while (bytes_sent < target) begin
            if ($urandom_range(99) < 85) send_unit();
            else send_noise();
        end
    endtask

    initial begin
        bytes_sent = 0;
        hold_seq = 0;
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        i_rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.stream_byte <= 8'h00;
        cfg_ch.valid <= 1'b0;
        cfg_ch.header_only_mode <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_mode(1'b0);
        // SPS opens the first frame
        send_code(2);
        send_byte(8'h67);
        // IDR slice after extra leading zeros, first macroblock set
        send_code(4);
        send_byte(8'h65);
        send_byte(8'h80);
        // slice without the first-macroblock bit is not counted
        send_code(2);
        send_byte(8'h41);
        send_byte(8'h00);
        // SEI ends the frame on a header
        send_code(2);
        send_byte(8'h06);
        // ignored NAL type
        send_code(2);
        send_byte(8'h1F);

        write_mode(1'b1);
        // header-only mode: the first counted slice ends the unit
        send_code(2);
        send_byte(8'h25);
        send_byte(8'hFF);
        // zero in the header position
        send_code(2);
        send_byte(BYTE_ZERO);

        send_idle_pct = 32;
        recv_idle_pct <= 58;
        run_random(580);

        write_mode(1'b0);
        send_idle_pct = 58;
        recv_idle_pct <= 32;
        run_random(580);

        write_mode(1'b1);
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        // long receiver hold-off while bytes keep coming
        hold_seq <= hold_seq + 1;
        run_random(590);

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
